### src/bmpru_pkg.sv
// Shared constants for the BMP pixel row unpacker.
// Register indexes, field widths and byte phase codes; no dependencies.
package bmpru_pkg;

    localparam int DEFAULT_MAX_DIMENSION = 4096;

    localparam int DIM_W   = 13;
    localparam int OFS_W   = 12;
    localparam int COORD_W = 14;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ROWS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_UP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE_PIXELS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET         = 3'd6;

    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;
    localparam logic [1:0] PH_SKIP  = 2'd3;

endpackage

### src/bmp_pixel_row_unpacker_top.sv
// BMP pixel row unpacker, top level.
// Depends on bmpru_pkg for register indexes, widths and byte phase codes.
//
// Takes one byte of an uncompressed 24/32-bit BMP pixel array per unstalled cycle
// and emits one pixel (channels plus screen coordinates) on each red byte,
// skipping the fourth byte of 32-bit pixels and the row padding. The byte
// path is a single pass of counter and coordinate logic into a one-entry
// output register, so the block sustains one byte per clock while the
// output is not stalled; in_stall rises only while a held pixel is itself stalled.
// cfg_ready is always high; configuration is meant to be written between
// images.
module bmp_pixel_row_unpacker_top #(
    parameter int MAX_DIMENSION = bmpru_pkg::DEFAULT_MAX_DIMENSION
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [bmpru_pkg::BYTE_W-1:0]           data_byte,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [bmpru_pkg::COORD_W-1:0]   x_pos,
    output logic signed [bmpru_pkg::COORD_W-1:0]   y_pos,
    output logic [bmpru_pkg::BYTE_W-1:0]           red,
    output logic [bmpru_pkg::BYTE_W-1:0]           green,
    output logic [bmpru_pkg::BYTE_W-1:0]           blue,
    output logic                                   last_pixel,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bmpru_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bmpru_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int CNT_W   = $clog2(MAX_DIMENSION);
    localparam int DIM_W   = bmpru_pkg::DIM_W;
    localparam int OFS_W   = bmpru_pkg::OFS_W;
    localparam int COORD_W = bmpru_pkg::COORD_W;
    localparam int BYTE_W  = bmpru_pkg::BYTE_W;

    // configuration
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic                    mirror_reg;
    logic                    bottom_up_reg;
    logic                    four_byte_reg;
    logic signed [OFS_W-1:0] x_ofs_reg;
    logic signed [OFS_W-1:0] y_ofs_reg;

    // unpack state
    logic [1:0]        phase_reg,  phase_next;
    logic [BYTE_W-1:0] blue_hold_reg,  blue_hold_next;
    logic [BYTE_W-1:0] green_hold_reg, green_hold_next;
    logic [CNT_W-1:0]  col_reg,    col_next;
    logic [CNT_W-1:0]  row_reg,    row_next;
    logic [1:0]        pad_reg,    pad_next;

    // output stage
    logic                      out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]        x_pos_reg;
    logic [COORD_W-1:0]        y_pos_reg;
    logic [BYTE_W-1:0]         red_reg;
    logic [BYTE_W-1:0]         green_reg;
    logic [BYTE_W-1:0]         blue_reg;
    logic                      last_reg;

    logic               in_xfer;
    logic               out_free;
    logic               emit;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic               col_last;
    logic               row_last;
    logic [COORD_W-1:0] x_base;
    logic [COORD_W-1:0] y_base;
    logic [COORD_W-1:0] x_calc;
    logic [COORD_W-1:0] y_calc;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_DIMENSION)
            r = DIM_W'(MAX_DIMENSION);
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !out_free;
    assign in_xfer   = in_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(1);
            height_reg    <= DIM_W'(1);
            mirror_reg    <= 1'b0;
            bottom_up_reg <= 1'b1;
            four_byte_reg <= 1'b0;
            x_ofs_reg     <= '0;
            y_ofs_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bmpru_pkg::CFG_IMAGE_WIDTH:      width_reg     <= cfg_data[DIM_W-1:0];
                bmpru_pkg::CFG_IMAGE_HEIGHT:     height_reg    <= cfg_data[DIM_W-1:0];
                bmpru_pkg::CFG_MIRROR_ROWS:      mirror_reg    <= cfg_data[0];
                bmpru_pkg::CFG_BOTTOM_UP:        bottom_up_reg <= cfg_data[0];
                bmpru_pkg::CFG_FOUR_BYTE_PIXELS: four_byte_reg <= cfg_data[0];
                bmpru_pkg::CFG_X_OFFSET:         x_ofs_reg     <= cfg_data[OFS_W-1:0];
                bmpru_pkg::CFG_Y_OFFSET:         y_ofs_reg     <= cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff    = clamp_dim(width_reg);
    assign h_eff    = clamp_dim(height_reg);
    assign col_last = (32'(col_reg) + 32'd1) >= 32'(w_eff);
    assign row_last = (32'(row_reg) + 32'd1) >= 32'(h_eff);

    // coordinates wrap modulo 2^14
    assign x_base = mirror_reg ? (COORD_W'(w_eff) - COORD_W'(1) - COORD_W'(col_reg))
                               : COORD_W'(col_reg);
    assign y_base = bottom_up_reg ? (COORD_W'(h_eff) - COORD_W'(1) - COORD_W'(row_reg))
                                  : COORD_W'(row_reg);
    assign x_calc = x_base + COORD_W'(x_ofs_reg);
    assign y_calc = y_base + COORD_W'(y_ofs_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        blue_hold_next  = blue_hold_reg;
        green_hold_next = green_hold_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pad_next        = pad_reg;
        emit            = 1'b0;
        if (in_xfer)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else
            begin
                case (phase_reg)
                    bmpru_pkg::PH_BLUE:
                    begin
                        blue_hold_next = data_byte;
                        phase_next     = bmpru_pkg::PH_GREEN;
                    end
                    bmpru_pkg::PH_GREEN:
                    begin
                        green_hold_next = data_byte;
                        phase_next      = bmpru_pkg::PH_RED;
                    end
                    default:
                    begin
                        if (phase_reg == bmpru_pkg::PH_RED)
                            emit = 1'b1;
                        if (phase_reg == bmpru_pkg::PH_RED && four_byte_reg)
                        begin
                            phase_next = bmpru_pkg::PH_SKIP;
                        end
                        else
                        begin
                            // pixel done
                            phase_next = bmpru_pkg::PH_BLUE;
                            if (col_last)
                            begin
                                col_next = '0;
                                row_next = row_last ? '0 : row_reg + CNT_W'(1);
                                pad_next = four_byte_reg ? 2'd0 : w_eff[1:0];
                            end
                            else
                            begin
                                col_next = col_reg + CNT_W'(1);
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bmpru_pkg::PH_BLUE;
            blue_hold_reg  <= '0;
            green_hold_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pad_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            blue_hold_reg  <= blue_hold_next;
            green_hold_reg <= green_hold_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pad_reg        <= pad_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            x_pos_reg <= x_calc;
            y_pos_reg <= y_calc;
            red_reg   <= data_byte;
            green_reg <= green_hold_reg;
            blue_reg  <= blue_hold_reg;
            last_reg  <= col_last && row_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign x_pos      = x_pos_reg;
    assign y_pos      = y_pos_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign last_pixel = last_reg;

`ifndef SYNTH
    // padding is only skipped between pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg != 2'd0 |-> phase_reg == bmpru_pkg::PH_BLUE)
        else $error("row padding pending in the middle of a pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && pad_reg == 2'd0 && phase_reg == bmpru_pkg::PH_RED |=> out_valid_reg)
        else $error("red byte transfer did not produce a pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && pad_reg != 2'd0 |=> pad_reg == $past(pad_reg) - 2'd1)
        else $error("padding count did not step down");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && pad_reg == 2'd0 && phase_reg == bmpru_pkg::PH_BLUE
        |=> blue_hold_reg == $past(data_byte) && phase_reg == bmpru_pkg::PH_GREEN)
        else $error("blue byte not captured");
`endif

endmodule
